FILE: hw/rtl/kdn_pkg.sv
// Shared types, codes and constants of the keepalive dead-node monitor.
package kdn_pkg;

   localparam int NUM_PEERS_DEF = 16;
   // Peer fields are 4 bits wide, so at most 16 table entries can ever be reached.
   localparam int PEER_W        = 4;
   localparam int PEER_SPAN     = 16;
   localparam int COUNT_W       = 8;
   localparam int SCAN_W        = 5;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 8;

   typedef enum logic [1:0] {
      ACT_RX   = 2'd0,
      ACT_TX   = 2'd1,
      ACT_TICK = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      EV_KEEPALIVE = 2'd0,
      EV_DEAD      = 2'd1,
      EV_RECONNECT = 2'd2
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MONITOR_ENABLE = 2'd0,
      REG_MISSED_LIMIT   = 2'd1,
      REG_OWN_NODE       = 2'd2,
      REG_NODES_IN_USE   = 2'd3
   } reg_index_type;

   localparam logic               MONITOR_ENABLE_RST = 1'b1;
   localparam logic [COUNT_W-1:0] MISSED_LIMIT_RST   = 8'd5;
   localparam logic [PEER_W-1:0]  OWN_NODE_RST       = 4'd0;
   localparam logic [SCAN_W-1:0]  NODES_IN_USE_RST   = 5'd16;

   // controller -> datapath
   typedef struct packed {
      logic mark;    // input beat taken in idle: apply rx/tx marks
      logic start;   // begin a scan at entry 0
      logic step;    // process the current entry
      logic flush;   // move the held event to the output with last set
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic tick;        // current input beat is an enabled interval tick
      logic scan_end;    // scan index reached the scan length
      logic step_ok;     // current entry can be processed this cycle
      logic pend_valid;  // an event is held back awaiting its last flag
      logic out_free;    // output register can load this cycle
   } sts_type;

endpackage

FILE: hw/rtl/keepalive_dead_node_monitor.sv
// Top level of the keepalive dead-node monitor.
//
// Input channel req_*: one beat per event. Receive and send marks (action 0
// and 1) are taken one per cycle while the block is idle and give no result.
// An interval tick (action 2) with monitoring enabled starts a scan of the
// peer table: one entry per cycle over min(nodes_in_use, table depth) entries
// while the result channel keeps up. req_tready stays low for the scan, so a
// tick holds intake until the scan ends and its last event is handed on.
// Result channel rsp_*: keepalive, dead and reconnect events in peer order.
// One event is held back until the next is found or the scan ends, so the
// final one can carry tlast; results pass the held event, then the output
// register. A stalled receiver halts the scan once both are full and the
// current entry yields an event; nothing is dropped. Configuration port
// csr_*: always ready; must be written only while idle, which is not checked.
// Reset (synchronous) clears the table and loads register defaults.
module keepalive_dead_node_monitor #(
   parameter int NUM_PEERS = kdn_pkg::NUM_PEERS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [3:0] peer
   input  logic [1:0]                     req_tuser,   // [1:0] action
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [3:0] peer_out
   output logic [1:0]                     rsp_tuser,   // [1:0] event_res
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kdn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kdn_pkg::CSR_DATA_W-1:0] csr_data
);

   kdn_pkg::cmd_type cmd;
   kdn_pkg::sts_type sts;

   kdn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kdn_dpath #(
      .NUM_PEERS (NUM_PEERS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hw/rtl/kdn_ctrl.sv
// Sequencer for the monitor: idle event intake and the per-tick table scan.
module kdn_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  kdn_pkg::sts_type sts,
   output kdn_pkg::cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.mark = 1'b1;
               if (sts.tick) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sts.scan_end) begin
               if (!sts.pend_valid) begin
                  state_in = ST_IDLE;
               end else if (sts.out_free) begin
                  cmd.flush = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (sts.step_ok) begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_start_scans: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == ST_SCAN))
      else $error("scan did not begin after start");
   a_flush_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> req_tready)
      else $error("intake not reopened after final event");
`endif

endmodule

FILE: hw/rtl/kdn_dpath.sv
// Peer table, configuration registers, held event and output register.
module kdn_dpath #(
   parameter int NUM_PEERS = kdn_pkg::NUM_PEERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        req_tdata,
   input  logic [1:0]                        req_tuser,
   input  kdn_pkg::cmd_type                  cmd,
   output kdn_pkg::sts_type                  sts,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kdn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kdn_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int TBL_D  = (NUM_PEERS < kdn_pkg::PEER_SPAN) ? NUM_PEERS : kdn_pkg::PEER_SPAN;
   localparam int TIDX_W = (TBL_D > 1) ? $clog2(TBL_D) : 1;
   localparam int CW     = kdn_pkg::COUNT_W;
   localparam int SW     = kdn_pkg::SCAN_W;
   localparam int PW     = kdn_pkg::PEER_W;

   // configuration
   logic          enable_ff;
   logic [CW-1:0] limit_ff;
   logic [PW-1:0] own_ff;
   logic [SW-1:0] in_use_ff;

   // table
   logic [TBL_D-1:0] rx_ff, rx_in, tx_ff, tx_in, dis_ff, dis_in;
   logic [CW-1:0]    miss_ff [TBL_D];
   logic [CW-1:0]    miss_in [TBL_D];

   // scan and events
   logic [SW-1:0]      cnt_ff, cnt_in;
   logic               pend_v_ff, pend_v_in;
   logic [PW-1:0]      pend_peer_ff, pend_peer_in;
   kdn_pkg::event_type pend_ev_ff, pend_ev_in;
   logic               out_v_ff, out_v_in;
   logic [PW-1:0]      out_peer_ff, out_peer_in;
   kdn_pkg::event_type out_ev_ff, out_ev_in;
   logic               out_last_ff, out_last_in;

   kdn_pkg::action_type act;
   logic [PW-1:0]       peer;
   logic                peer_ok;
   logic [TIDX_W-1:0]   pidx, sidx;
   logic [SW-1:0]       scan_len;
   logic                load_out;

   // current entry evaluation
   logic               skip, c_rx, c_tx, c_dis;
   logic [CW-1:0]      c_miss, n_miss;
   logic               ev_v;
   kdn_pkg::event_type ev;

   assign act      = kdn_pkg::action_type'(req_tuser);
   assign peer     = req_tdata[PW-1:0];
   assign peer_ok  = (SW'(peer) < SW'(TBL_D));
   assign pidx     = peer[TIDX_W-1:0];
   assign sidx     = cnt_ff[TIDX_W-1:0];
   assign scan_len = (in_use_ff < SW'(TBL_D)) ? in_use_ff : SW'(TBL_D);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= kdn_pkg::MONITOR_ENABLE_RST;
         limit_ff  <= kdn_pkg::MISSED_LIMIT_RST;
         own_ff    <= kdn_pkg::OWN_NODE_RST;
         in_use_ff <= kdn_pkg::NODES_IN_USE_RST;
      end else if (csr_valid) begin
         case (kdn_pkg::reg_index_type'(csr_index))
            kdn_pkg::REG_MONITOR_ENABLE: enable_ff <= csr_data[0];
            kdn_pkg::REG_MISSED_LIMIT:   limit_ff  <= csr_data;
            kdn_pkg::REG_OWN_NODE:       own_ff    <= csr_data[PW-1:0];
            kdn_pkg::REG_NODES_IN_USE:   in_use_ff <= csr_data[SW-1:0];
            default: ;
         endcase
      end
   end

   // what the current scan entry does
   always_comb begin
      skip   = (cnt_ff == SW'(own_ff));
      c_rx   = rx_ff[sidx];
      c_tx   = tx_ff[sidx];
      c_dis  = dis_ff[sidx];
      c_miss = miss_ff[sidx];
      if (c_rx) begin
         n_miss = '0;
      end else if (c_miss == {CW{1'b1}}) begin
         n_miss = c_miss;
      end else begin
         n_miss = c_miss + CW'(1);
      end
      ev_v = 1'b0;
      ev   = kdn_pkg::EV_KEEPALIVE;
      if (skip) begin
         ev_v = 1'b0;
      end else if (c_dis) begin
         ev_v = c_rx;
         ev   = kdn_pkg::EV_RECONNECT;
      end else if (n_miss >= limit_ff) begin
         ev_v = 1'b1;
         ev   = kdn_pkg::EV_DEAD;
      end else begin
         ev_v = !c_tx;
         ev   = kdn_pkg::EV_KEEPALIVE;
      end
   end

   assign sts.tick       = (act == kdn_pkg::ACT_TICK) && enable_ff;
   assign sts.scan_end   = (cnt_ff >= scan_len);
   assign sts.out_free   = !out_v_ff || rsp_tready;
   assign sts.pend_valid = pend_v_ff;
   assign sts.step_ok    = !(ev_v && pend_v_ff && !sts.out_free);

   // table update
   always_comb begin
      rx_in   = rx_ff;
      tx_in   = tx_ff;
      dis_in  = dis_ff;
      miss_in = miss_ff;
      if (cmd.mark && peer_ok) begin
         if (act == kdn_pkg::ACT_RX) begin
            rx_in[pidx] = 1'b1;
         end else if (act == kdn_pkg::ACT_TX) begin
            tx_in[pidx] = 1'b1;
         end
      end
      if (cmd.step && !skip) begin
         if (c_dis) begin
            if (c_rx) begin
               dis_in[sidx]  = 1'b0;
               miss_in[sidx] = '0;
            end
         end else begin
            miss_in[sidx] = n_miss;
            rx_in[sidx]   = 1'b0;
            if (n_miss >= limit_ff) begin
               dis_in[sidx] = 1'b1;
            end else begin
               tx_in[sidx] = 1'b0;
            end
         end
      end
   end

   // scan counter, held event, output register
   always_comb begin
      cnt_in       = cnt_ff;
      pend_v_in    = pend_v_ff;
      pend_peer_in = pend_peer_ff;
      pend_ev_in   = pend_ev_ff;
      load_out     = 1'b0;
      out_peer_in  = out_peer_ff;
      out_ev_in    = out_ev_ff;
      out_last_in  = out_last_ff;
      if (cmd.start) begin
         cnt_in = '0;
      end
      if (cmd.step) begin
         cnt_in = cnt_ff + SW'(1);
         if (ev_v) begin
            if (pend_v_ff) begin
               load_out    = 1'b1;
               out_peer_in = pend_peer_ff;
               out_ev_in   = pend_ev_ff;
               out_last_in = 1'b0;
            end
            pend_v_in    = 1'b1;
            pend_peer_in = cnt_ff[PW-1:0];
            pend_ev_in   = ev;
         end
      end
      if (cmd.flush) begin
         load_out    = 1'b1;
         out_peer_in = pend_peer_ff;
         out_ev_in   = pend_ev_ff;
         out_last_in = 1'b1;
         pend_v_in   = 1'b0;
      end
      if (load_out) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff     <= '0;
         tx_ff     <= '0;
         dis_ff    <= '0;
         for (int i = 0; i < TBL_D; i++) begin
            miss_ff[i] <= '0;
         end
         cnt_ff    <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         rx_ff     <= rx_in;
         tx_ff     <= tx_in;
         dis_ff    <= dis_in;
         miss_ff   <= miss_in;
         cnt_ff    <= cnt_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_peer_ff <= pend_peer_in;
      pend_ev_ff   <= pend_ev_in;
      out_peer_ff  <= out_peer_in;
      out_ev_ff    <= out_ev_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'b0000, out_peer_ff};
   assign rsp_tuser  = out_ev_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef ASSERT_OFF
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!out_v_ff || rsp_tready))
      else $error("output register overwritten while stalled");
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !pend_v_ff)
      else $error("scan started with an event still held");
   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (!pend_v_ff && out_v_ff && out_last_ff))
      else $error("final event not presented with last");
`endif

endmodule

FILE: sim/kdn_event_checker.sv
`timescale 1ns / 100ps
// Checker for the dead-node monitor: mirrors the peer table, predicts scan events, compares.
module kdn_event_checker #(
   parameter int NUM_PEERS = kdn_pkg::NUM_PEERS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [3:0] peer
   input  logic [1:0]                     req_tuser,   // [1:0] action
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [7:0]                     rsp_tdata,   // [3:0] peer_out
   input  logic [1:0]                     rsp_tuser,   // [1:0] event_res
   input  logic                           rsp_tlast,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [kdn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kdn_pkg::CSR_DATA_W-1:0] csr_data,
   output int unsigned                    fail_count,
   output int unsigned                    expected_left
);

   localparam int PW   = kdn_pkg::PEER_W;
   localparam int SPAN = kdn_pkg::PEER_SPAN;
   localparam int CW   = kdn_pkg::COUNT_W;
   localparam int SW   = kdn_pkg::SCAN_W;
   localparam int IW   = kdn_pkg::CSR_IDX_W;
   localparam int DW   = kdn_pkg::CSR_DATA_W;

   typedef struct packed {
      logic [PW-1:0]      peer;
      kdn_pkg::event_type ev;
      logic               last;
   } peer_event_type;

   peer_event_type     event_q [$];

   logic               rx_mark  [SPAN];
   logic               tx_mark  [SPAN];
   logic               offline  [SPAN];
   logic [CW-1:0]      miss_cnt [SPAN];

   logic               mon_en;
   logic [CW-1:0]      limit_cfg;
   logic [PW-1:0]      own_cfg;
   logic [SW-1:0]      span_cfg;
   int unsigned        mismatches;

   task automatic clear_table();
      for (int i = 0; i < SPAN; i++) begin
         rx_mark[i]  = 1'b0;
         tx_mark[i]  = 1'b0;
         offline[i]  = 1'b0;
         miss_cnt[i] = '0;
      end
      mon_en     = kdn_pkg::MONITOR_ENABLE_RST;
      limit_cfg  = kdn_pkg::MISSED_LIMIT_RST;
      own_cfg    = kdn_pkg::OWN_NODE_RST;
      span_cfg   = kdn_pkg::NODES_IN_USE_RST;
      mismatches = 0;
      event_q.delete();
   endtask

   // One tick: walk the table in index order, collect events, flag the final one.
   task automatic scan_table();
      logic [PW-1:0]      hit_peer [SPAN];
      kdn_pkg::event_type hit_ev   [SPAN];
      int                 hits;
      int                 span;
      hits = 0;
      span = int'(span_cfg);
      if (span > NUM_PEERS) span = NUM_PEERS;
      if (span > SPAN) span = SPAN;
      for (int i = 0; i < span; i++) begin
         if (i == int'(own_cfg)) continue;
         if (offline[i]) begin
            if (rx_mark[i]) begin
               offline[i]     = 1'b0;
               miss_cnt[i]    = '0;
               hit_peer[hits] = PW'(i);
               hit_ev[hits]   = kdn_pkg::EV_RECONNECT;
               hits++;
            end
            continue;
         end
         if (!rx_mark[i]) begin
            if (miss_cnt[i] != 8'hFF) miss_cnt[i] = miss_cnt[i] + 8'd1;
         end else begin
            miss_cnt[i] = '0;
         end
         rx_mark[i] = 1'b0;
         // dead peer keeps its count and its send mark
         if (miss_cnt[i] >= limit_cfg) begin
            offline[i]     = 1'b1;
            hit_peer[hits] = PW'(i);
            hit_ev[hits]   = kdn_pkg::EV_DEAD;
            hits++;
            continue;
         end
         if (!tx_mark[i]) begin
            hit_peer[hits] = PW'(i);
            hit_ev[hits]   = kdn_pkg::EV_KEEPALIVE;
            hits++;
         end
         tx_mark[i] = 1'b0;
      end
      for (int k = 0; k < hits; k++)
         event_q.push_back('{peer: hit_peer[k], ev: hit_ev[k], last: (k == hits - 1)});
   endtask

   task automatic take_beat(input logic [1:0] kind, input logic [7:0] beat);
      kdn_pkg::action_type act;
      logic [PW-1:0]       pid;
      act = kdn_pkg::action_type'(kind);
      pid = beat[PW-1:0];
      case (act)
         kdn_pkg::ACT_RX: begin
            if (int'(pid) < NUM_PEERS) rx_mark[pid] = 1'b1;
         end
         kdn_pkg::ACT_TX: begin
            if (int'(pid) < NUM_PEERS) tx_mark[pid] = 1'b1;
         end
         kdn_pkg::ACT_TICK: begin
            if (mon_en) scan_table();
         end
         default: ;
      endcase
   endtask

   task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
      case (kdn_pkg::reg_index_type'(idx))
         kdn_pkg::REG_MONITOR_ENABLE: mon_en    = data[0];
         kdn_pkg::REG_MISSED_LIMIT:   limit_cfg = data[CW-1:0];
         kdn_pkg::REG_OWN_NODE:       own_cfg   = data[PW-1:0];
         kdn_pkg::REG_NODES_IN_USE:   span_cfg  = data[SW-1:0];
         default: ;
      endcase
   endtask

   task automatic check_event();
      peer_event_type want;
      if (event_q.size() == 0) begin
         mismatches++;
         $display("%0t: event with none expected: got peer_out %0d event_res %0d last %0b",
                  $time, rsp_tdata[3:0], rsp_tuser, rsp_tlast);
      end else begin
         want = event_q.pop_front();
         if (rsp_tdata[3:0] !== want.peer || rsp_tuser !== want.ev ||
             rsp_tdata[7:4] !== 4'h0 || rsp_tlast !== want.last) begin
            mismatches++;
            $display("%0t: event mismatch: expected peer_out %0d event_res %0d pad 0 last %0b",
                     $time, want.peer, want.ev, want.last);
            $display("%0t:                 actual   peer_out %0d event_res %0d pad %0d last %0b",
                     $time, rsp_tdata[3:0], rsp_tuser, rsp_tdata[7:4], rsp_tlast);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_table();
      end else begin
         if (csr_valid && csr_ready) write_reg(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready) check_event();
         if (req_tvalid && req_tready) take_beat(req_tuser, req_tdata);
      end
      fail_count    <= mismatches;
      expected_left <= event_q.size();
   end

endmodule

FILE: sim/keepalive_dead_node_monitor_tb.sv
`timescale 1ns / 100ps
// Testbench top for the dead-node monitor: clock, reset, stimulus, back-pressure and verdict.
module keepalive_dead_node_monitor_tb;

   localparam int HOLD_LEN       = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SCAN_SETTLE    = 40;
   localparam int PW             = kdn_pkg::PEER_W;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   kdn_pkg::reg_index_type csr_index  = kdn_pkg::REG_MONITOR_ENABLE;
   logic [7:0]             csr_data   = '0;

   int unsigned   fail_count;
   int unsigned   expected_left;
   int unsigned   req_idle_pct = 0;
   int unsigned   rsp_idle_pct = 0;
   logic          stall_go     = 1'b0;
   int unsigned   hold_cnt     = 0;
   int unsigned   quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   keepalive_dead_node_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   kdn_event_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   // Receiver: random back-pressure, plus one long hold-off once requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_go && hold_cnt < HOLD_LEN) begin
         rsp_tready <= 1'b0;
         hold_cnt   <= hold_cnt + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic offer_beat(input kdn_pkg::action_type act, input logic [PW-1:0] pid);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, pid};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(input kdn_pkg::reg_index_type idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_monitor(input logic [7:0] en, input logic [7:0] limit,
                                  input logic [7:0] own, input logic [7:0] nodes);
      write_csr(kdn_pkg::REG_MONITOR_ENABLE, en);
      write_csr(kdn_pkg::REG_MISSED_LIMIT, limit);
      write_csr(kdn_pkg::REG_OWN_NODE, own);
      write_csr(kdn_pkg::REG_NODES_IN_USE, nodes);
      csr_valid <= 1'b0;
   endtask

   // Drain all events, then give a silent scan time to finish before touching registers.
   task automatic settle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SCAN_SETTLE) @(posedge clock);
   endtask

   task automatic random_settings();
      logic [7:0] en;
      logic [7:0] limit;
      logic [7:0] nodes;
      int unsigned r;
      en = ($urandom_range(9) != 0) ? 8'h01 : 8'h00;
      r = $urandom_range(9);
      case (r)
         0:       limit = 8'd1;
         1:       limit = 8'd255;
         2:       limit = 8'($urandom_range(255));
         default: limit = 8'($urandom_range(1, 6));
      endcase
      r = $urandom_range(9);
      case (r)
         0, 1, 2: nodes = 8'd16;
         3:       nodes = 8'd1;
         4:       nodes = 8'($urandom_range(255));
         default: nodes = 8'($urandom_range(1, 16));
      endcase
      program_monitor(en, limit, 8'($urandom_range(255)), nodes);
   endtask

   task automatic run_traffic(input int count, input int unsigned tick_pct);
      kdn_pkg::action_type act;
      int unsigned         r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < tick_pct)
            act = kdn_pkg::ACT_TICK;
         else if (r < tick_pct + 4)
            act = kdn_pkg::ACT_NONE;
         else
            act = $urandom_range(1) ? kdn_pkg::ACT_RX : kdn_pkg::ACT_TX;
         offer_beat(act, PW'($urandom_range(15)));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // keepalives, deaths and a reconnect, own node at the top index
      program_monitor(8'h01, 8'd2, 8'd15, 8'd16);
      offer_beat(kdn_pkg::ACT_TX, 4'd5);
      offer_beat(kdn_pkg::ACT_RX, 4'd6);
      offer_beat(kdn_pkg::ACT_RX, 4'd0);
      offer_beat(kdn_pkg::ACT_NONE, 4'd15);
      offer_beat(kdn_pkg::ACT_TICK, 4'd10);
      offer_beat(kdn_pkg::ACT_TICK, 4'd0);
      offer_beat(kdn_pkg::ACT_RX, 4'd15);
      offer_beat(kdn_pkg::ACT_RX, 4'd2);
      offer_beat(kdn_pkg::ACT_TICK, 4'd15);
      offer_beat(kdn_pkg::ACT_TX, 4'd14);
      settle();

      // zero limit: every connected peer dies at once
      program_monitor(8'h01, 8'd0, 8'd3, 8'd8);
      offer_beat(kdn_pkg::ACT_RX, 4'd3);
      offer_beat(kdn_pkg::ACT_RX, 4'd4);
      offer_beat(kdn_pkg::ACT_TICK, 4'd5);
      settle();

      program_monitor(8'h00, 8'd0, 8'd3, 8'd8);
      offer_beat(kdn_pkg::ACT_TICK, 4'd1);
      offer_beat(kdn_pkg::ACT_RX, 4'd1);
      settle();

      // own node outside the scanned range, upper data bits ignored
      program_monitor(8'h81, 8'd255, 8'd12, 8'd8);
      offer_beat(kdn_pkg::ACT_RX, 4'd1);
      offer_beat(kdn_pkg::ACT_TICK, 4'd12);
      offer_beat(kdn_pkg::ACT_TICK, 4'd3);
      settle();

      program_monitor(8'h01, 8'd255, 8'd12, 8'd0);
      offer_beat(kdn_pkg::ACT_TICK, 4'd7);
      settle();

      program_monitor(8'h01, 8'd1, 8'd0, 8'd1);
      offer_beat(kdn_pkg::ACT_TICK, 4'd8);
      settle();

      program_monitor(8'h01, 8'd1, 8'hF3, 8'hFF);
      offer_beat(kdn_pkg::ACT_RX, 4'd7);
      offer_beat(kdn_pkg::ACT_TICK, 4'd9);

      for (int mode = 0; mode < 3; mode++) begin
         req_idle_pct <= (mode == 0) ? 33 : (mode == 1) ? 60 : 0;
         rsp_idle_pct <= (mode == 0) ? 60 : (mode == 1) ? 33 : 0;
         for (int sub = 0; sub < 3; sub++) begin
            settle();
            random_settings();
            if (mode == 2 && sub == 0) begin
               stall_go <= 1'b1;
               run_traffic(48, 40);
            end else begin
               run_traffic(48, 18);
            end
         end
      end

      settle();
      if (fail_count == 0 && expected_left == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/kdn_pkg.sv
hw/rtl/kdn_ctrl.sv
hw/rtl/kdn_dpath.sv
hw/rtl/keepalive_dead_node_monitor.sv
sim/kdn_event_checker.sv
sim/keepalive_dead_node_monitor_tb.sv
